// ----- rtl/core/res_pkg.sv -----
// shared types and constants of the repressilator euler stepper
package res_pkg;

   localparam int unsigned QW = 32;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_START  = 2'd1;
   localparam logic [1:0] STATUS_PAST_END  = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [2:0] REG_START_TIME = 3'd0;
   localparam logic [2:0] REG_END_TIME   = 3'd1;
   localparam logic [2:0] REG_STEP_SIZE  = 3'd2;
   localparam logic [2:0] REG_MAX_RATE   = 3'd3;
   localparam logic [2:0] REG_LEAK_RATE  = 3'd4;
   localparam logic [2:0] REG_HILL_EXP   = 3'd5;
   localparam logic [2:0] REG_DECAY      = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POW,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MDERIV,
      ST_PDERIV,
      ST_MUPD,
      ST_PUPD,
      ST_NEXT_GENE,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic init_pow;
      logic pow_mul;
      logic div_start;
      logic mderiv;
      logic pderiv;
      logic mupd;
      logic pupd;
      logic next_gene;
      logic commit;
      logic early_result;
      logic rsp_set;
      logic rsp_clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pow_done;
      logic div_done;
      logic last_gene;
      logic loaded;
      logic past_end;
      logic rsp_full;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) r = 32'sh7fffffff;
      else if (x < -66'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

// ----- rtl/core/res_stream_if.sv -----
// valid/ready channel interfaces for request, response and csr writes
interface res_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] init_mrna_a;
   logic signed [31:0] init_mrna_b;
   logic signed [31:0] init_mrna_c;
   logic signed [31:0] init_prot_a;
   logic signed [31:0] init_prot_b;
   logic signed [31:0] init_prot_c;
   modport source (output valid, command, init_mrna_a, init_mrna_b, init_mrna_c,
                   init_prot_a, init_prot_b, init_prot_c, input ready);
   modport sink (input valid, command, init_mrna_a, init_mrna_b, init_mrna_c,
                 init_prot_a, init_prot_b, init_prot_c, output ready);
endinterface

interface res_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_time;
   logic signed [31:0] reporter_level;
   logic [1:0]         step_status;
   modport source (output valid, sample_time, reporter_level, step_status, input ready);
   modport sink (input valid, sample_time, reporter_level, step_status, output ready);
endinterface

interface res_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/res_div.sv -----
// restoring divider, one quotient bit per cycle, signed with truncation to zero
module res_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] numer,
   input  logic signed [63:0] denom,
   output logic               done,
   output logic signed [63:0] quot
);
   logic [63:0] q_ff, q_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;
   logic [63:0] r_shift;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      r_shift = {r_ff[62:0], q_ff[63]};
      trial = {1'b0, r_shift} - {1'b0, d_ff};
      if (start) begin
         q_in = numer[63] ? 64'(-numer) : numer;
         d_in = denom[63] ? 64'(-denom) : denom;
         r_in = '0;
         neg_in = numer[63] ^ denom[63];
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = r_shift;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign done = !busy_ff && !start;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

// ----- rtl/core/res_datapath.sv -----
// state registers, shared multiplier and divider of the euler stepper
module res_datapath #(
   parameter int FRAC_BITS = 20,
   parameter int MAX_HILL  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  res_pkg::cmd_type    cmd,
   output res_pkg::status_type status,
   input  logic [31:0]        in_mrna [3],
   input  logic [31:0]        in_prot [3],
   input  logic signed [31:0] origin_time,
   input  logic signed [31:0] stop_time,
   input  logic [30:0]        dt_step,
   input  logic signed [31:0] max_rate,
   input  logic signed [31:0] leak_rate,
   input  logic [3:0]         hill_exponent,
   input  logic signed [31:0] decay_ratio,
   output logic signed [31:0] rsp_time,
   output logic signed [31:0] rsp_level,
   output logic [1:0]         rsp_status
);
   localparam int HW = $clog2(MAX_HILL + 1) + 1;
   localparam logic signed [63:0] QONE = 64'sd1 <<< FRAC_BITS;

   logic signed [31:0] m_ff [3];
   logic signed [31:0] p_ff [3];
   logic signed [31:0] nm_ff [3];
   logic signed [31:0] np_ff [3];
   logic signed [31:0] t_ff;
   logic               loaded_ff;
   logic [1:0]         g_ff;
   logic signed [31:0] pw_ff;
   logic [HW-1:0]      k_ff;
   logic signed [31:0] dm_ff, dp_ff;
   logic               full_ff;
   logic signed [31:0] rt_ff, rl_ff;
   logic [1:0]         rs_ff;

   logic [HW-1:0]      n_clamp;
   logic signed [31:0] rep;
   logic signed [63:0] mul_a, mul_b, prod;
   logic signed [31:0] qm;
   logic signed [63:0] den;
   logic               div_done;
   logic signed [63:0] div_q;
   logic signed [31:0] hill;

   always_comb begin
      if (hill_exponent == 4'd0) n_clamp = HW'(1);
      else if (32'(hill_exponent) > MAX_HILL) n_clamp = HW'(MAX_HILL);
      else n_clamp = HW'(hill_exponent);
   end

   always_comb begin
      unique case (g_ff)
         2'd0: rep = p_ff[2];
         2'd1: rep = p_ff[0];
         default: rep = p_ff[1];
      endcase
   end

   // one shared q multiplier with round half up and saturation
   always_comb begin
      mul_a = 64'(pw_ff);
      mul_b = 64'(rep);
      if (cmd.pderiv) begin
         mul_a = 64'(decay_ratio);
         mul_b = 64'(res_pkg::sat32(66'(m_ff[g_ff]) - 66'(p_ff[g_ff])));
      end else if (cmd.mupd) begin
         mul_a = 64'($signed({1'b0, dt_step}));
         mul_b = 64'(dm_ff);
      end else if (cmd.pupd) begin
         mul_a = 64'($signed({1'b0, dt_step}));
         mul_b = 64'(dp_ff);
      end
      prod = mul_a * mul_b + (64'sd1 <<< (FRAC_BITS - 1));
      qm = res_pkg::sat32(66'(prod >>> FRAC_BITS));
   end

   assign den = QONE + 64'(pw_ff);

   res_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (64'(max_rate) <<< FRAC_BITS),
      .denom (den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      if (den == 64'sd0) begin
         if (max_rate > 0) hill = 32'sh7fffffff;
         else if (max_rate < 0) hill = 32'sh80000000;
         else hill = '0;
      end else begin
         hill = res_pkg::sat32(66'(div_q));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= '0;
            p_ff[i] <= '0;
         end
         t_ff <= '0;
         loaded_ff <= 1'b0;
         full_ff <= 1'b0;
         g_ff <= '0;
      end else begin
         if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
               m_ff[i] <= in_mrna[i];
               p_ff[i] <= in_prot[i];
            end
            t_ff <= origin_time;
            loaded_ff <= 1'b1;
            g_ff <= '0;
         end
         if (cmd.init_pow) begin
            pw_ff <= rep;
            k_ff <= HW'(1);
         end
         if (cmd.pow_mul) begin
            pw_ff <= qm;
            k_ff <= k_ff + HW'(1);
         end
         if (cmd.mderiv)
            dm_ff <= res_pkg::sat32(66'(hill) + 66'(leak_rate) - 66'(m_ff[g_ff]));
         if (cmd.pderiv) dp_ff <= qm;
         if (cmd.mupd) nm_ff[g_ff] <= res_pkg::sat32(66'(m_ff[g_ff]) + 66'(qm));
         if (cmd.pupd) np_ff[g_ff] <= res_pkg::sat32(66'(p_ff[g_ff]) + 66'(qm));
         if (cmd.next_gene) begin
            g_ff <= g_ff + 2'd1;
            // the next gene is repressed by the protein of the current one
            pw_ff <= p_ff[g_ff];
            k_ff <= HW'(1);
         end
         if (cmd.commit) begin
            for (int i = 0; i < 3; i++) begin
               m_ff[i] <= nm_ff[i];
               p_ff[i] <= np_ff[i];
            end
            t_ff <= res_pkg::sat32(66'(t_ff) + 66'(dt_step));
            g_ff <= '0;
            rt_ff <= t_ff;
            rl_ff <= np_ff[1];
            rs_ff <= res_pkg::STATUS_OK;
         end
         if (cmd.early_result) begin
            rt_ff <= loaded_ff ? t_ff : '0;
            rl_ff <= loaded_ff ? p_ff[1] : '0;
            rs_ff <= loaded_ff ? res_pkg::STATUS_PAST_END : res_pkg::STATUS_NO_START;
         end
         if (cmd.rsp_set) full_ff <= 1'b1;
         else if (cmd.rsp_clear) full_ff <= 1'b0;
      end
   end

   assign status.pow_done  = (k_ff >= n_clamp);
   assign status.div_done  = div_done;
   assign status.last_gene = (g_ff == 2'd2);
   assign status.loaded    = loaded_ff;
   assign status.past_end  = (t_ff > stop_time);
   assign status.rsp_full  = full_ff;

   assign rsp_time   = rt_ff;
   assign rsp_level  = rl_ff;
   assign rsp_status = rs_ff;
endmodule

// ----- rtl/core/res_ctrl.sv -----
// sequencer for load and step transactions
module res_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_command,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  res_pkg::status_type status,
   output res_pkg::cmd_type    cmd
);
   res_pkg::state_type state_ff, state_in;
   logic accept, rsp_take;

   assign req_ready = (state_ff == res_pkg::ST_IDLE) && !status.rsp_full;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = status.rsp_full;
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         res_pkg::ST_IDLE:
            if (accept && req_command == res_pkg::CMD_STEP) begin
               if (!status.loaded || status.past_end) state_in = res_pkg::ST_RESULT;
               else state_in = res_pkg::ST_POW;
            end
         res_pkg::ST_POW:
            if (status.pow_done) state_in = res_pkg::ST_DIV_START;
         res_pkg::ST_DIV_START: state_in = res_pkg::ST_DIV_WAIT;
         res_pkg::ST_DIV_WAIT:
            if (status.div_done) state_in = res_pkg::ST_MDERIV;
         res_pkg::ST_MDERIV: state_in = res_pkg::ST_PDERIV;
         res_pkg::ST_PDERIV: state_in = res_pkg::ST_MUPD;
         res_pkg::ST_MUPD:   state_in = res_pkg::ST_PUPD;
         res_pkg::ST_PUPD:   state_in = res_pkg::ST_NEXT_GENE;
         res_pkg::ST_NEXT_GENE:
            state_in = status.last_gene ? res_pkg::ST_COMMIT : res_pkg::ST_POW;
         res_pkg::ST_COMMIT: state_in = res_pkg::ST_IDLE;
         res_pkg::ST_RESULT: state_in = res_pkg::ST_IDLE;
         default: state_in = res_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_clear = rsp_take;
      unique case (state_ff)
         res_pkg::ST_IDLE: begin
            cmd.load = accept && req_command == res_pkg::CMD_LOAD;
            cmd.init_pow = accept && req_command == res_pkg::CMD_STEP;
         end
         res_pkg::ST_POW: cmd.pow_mul = !status.pow_done;
         res_pkg::ST_DIV_START: cmd.div_start = 1'b1;
         res_pkg::ST_MDERIV: cmd.mderiv = 1'b1;
         res_pkg::ST_PDERIV: cmd.pderiv = 1'b1;
         res_pkg::ST_MUPD: cmd.mupd = 1'b1;
         res_pkg::ST_PUPD: cmd.pupd = 1'b1;
         // next gene: load its repressor as the first power term
         res_pkg::ST_NEXT_GENE: cmd.next_gene = !status.last_gene;
         res_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.rsp_set = 1'b1;
         end
         res_pkg::ST_RESULT: begin
            cmd.early_result = 1'b1;
            cmd.rsp_set = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= res_pkg::ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ----- rtl/core/repressilator_euler_step_core.sv -----
// top level: csr bank, controller and datapath of the repressilator euler stepper
// a load is stored when accepted; a step runs, per gene, the power loop up to the clamped
// hill exponent n, one division and the derivative and update states, then commits;
// early steps (not loaded or past end time) go straight to the result state
// one transaction at a time; the next request is taken once the result has been taken
// synchronous active-high reset clears state, time and registers to their reset values
module repressilator_euler_step_core #(
   parameter int FRAC_BITS = 20,
   parameter int MAX_HILL  = 8
) (
   input logic    clock,
   input logic    reset,
   res_req_if.sink   req,
   res_rsp_if.source rsp,
   res_csr_if.sink   csr
);
   logic signed [31:0] origin_time_ff, stop_time_ff, max_rate_ff, leak_rate_ff, decay_ff;
   logic [30:0] dt_step_ff;
   logic [3:0]  hill_ff;
   res_pkg::cmd_type    cmd;
   res_pkg::status_type status;
   logic [31:0] in_mrna [3];
   logic [31:0] in_prot [3];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_time_ff <= '0;
         stop_time_ff <= '0;
         dt_step_ff <= 31'd10486;
         max_rate_ff <= '0;
         leak_rate_ff <= '0;
         hill_ff <= 4'd2;
         decay_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            res_pkg::REG_START_TIME: origin_time_ff <= csr.data;
            res_pkg::REG_END_TIME:   stop_time_ff <= csr.data;
            res_pkg::REG_STEP_SIZE:  dt_step_ff <= csr.data[30:0];
            res_pkg::REG_MAX_RATE:   max_rate_ff <= csr.data;
            res_pkg::REG_LEAK_RATE:  leak_rate_ff <= csr.data;
            res_pkg::REG_HILL_EXP:   hill_ff <= csr.data[3:0];
            res_pkg::REG_DECAY:      decay_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign in_mrna[0] = req.init_mrna_a;
   assign in_mrna[1] = req.init_mrna_b;
   assign in_mrna[2] = req.init_mrna_c;
   assign in_prot[0] = req.init_prot_a;
   assign in_prot[1] = req.init_prot_b;
   assign in_prot[2] = req.init_prot_c;

   res_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_ready   (req.ready),
      .rsp_ready   (rsp.ready),
      .rsp_valid   (rsp.valid),
      .status      (status),
      .cmd         (cmd)
   );

   res_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_HILL(MAX_HILL)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_mrna       (in_mrna),
      .in_prot       (in_prot),
      .origin_time   (origin_time_ff),
      .stop_time     (stop_time_ff),
      .dt_step       (dt_step_ff),
      .max_rate      (max_rate_ff),
      .leak_rate     (leak_rate_ff),
      .hill_exponent (hill_ff),
      .decay_ratio   (decay_ff),
      .rsp_time      (rsp.sample_time),
      .rsp_level     (rsp.reporter_level),
      .rsp_status    (rsp.step_status)
   );
endmodule

// ----- rtl/core/res_checker.sv -----
// port-level checks of the repressilator euler stepper, bound to the top level
module res_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_step_status,
   input logic [31:0] rsp_sample_time
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_status != 2'd3) else $error("bad status code");
   a_no_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_status == res_pkg::STATUS_NO_START |-> rsp_sample_time == '0)
      else $error("no-start result with nonzero time");
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_time))
      else $error("result dropped while stalled");
endmodule

bind repressilator_euler_step_core res_checker u_res_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_step_status (rsp.step_status),
   .rsp_sample_time (rsp.sample_time)
);

// ----- test/euler_step_checker.sv -----
// watches the stepper channels, predicts each step result and compares it
module euler_step_checker #(
   parameter int FRAC = 20,
   parameter int HILL_LIMIT = 8
) (
   input  logic clock,
   input  logic reset,
   res_req_if   req,
   res_rsp_if   rsp,
   res_csr_if   csr,
   output int   mismatch_count,
   output int   samples_pending
);

   localparam longint ONE = longint'(1) << FRAC;

   typedef struct {
      logic signed [31:0] sample_time;
      logic signed [31:0] reporter_level;
      logic [1:0]         step_status;
   } sample_type;

   sample_type expected_samples[$];

   // register copy
   logic signed [31:0] t_origin, t_stop, max_rate, leak_rate, decay_ratio;
   logic [30:0]        h_len;
   logic [3:0]         hill_exp;

   // gene state: index 0 lacI, 1 tetR, 2 cI
   logic signed [31:0] mrna[3];
   logic signed [31:0] prot[3];
   logic signed [31:0] now_time;
   bit                 loaded;

   function automatic logic signed [31:0] clamp32(longint x);
      if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (x < longint'(32'sh80000000)) return 32'sh80000000;
      return x[31:0];
   endfunction

   // fixed point product, rounded half up
   function automatic logic signed [31:0] q_product(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC - 1));
      return clamp32(p >>> FRAC);
   endfunction

   function automatic logic signed [31:0] repression(logic signed [31:0] p);
      int n;
      logic signed [31:0] pw;
      longint den, num;
      n = hill_exp;
      if (n < 1) n = 1;
      if (n > HILL_LIMIT) n = HILL_LIMIT;
      pw = p;
      for (int i = 1; i < n; i++) pw = q_product(pw, p);
      den = ONE + longint'(pw);
      if (den == 0) begin
         if (max_rate > 0) return 32'sh7fffffff;
         if (max_rate < 0) return 32'sh80000000;
         return 0;
      end
      num = longint'(max_rate) * ONE;
      return clamp32(num / den);
   endfunction

   task automatic euler_advance(output sample_type s);
      logic signed [31:0] dm[3], dp[3], diff;
      longint h;
      h = longint'({1'b0, h_len});
      if (!loaded) begin
         s = '{0, 0, res_pkg::STATUS_NO_START};
         return;
      end
      if (now_time > t_stop) begin
         s = '{now_time, prot[1], res_pkg::STATUS_PAST_END};
         return;
      end
      for (int i = 0; i < 3; i++) begin
         dm[i] = clamp32(-longint'(mrna[i]) + longint'(repression(prot[(i + 2) % 3]))
                         + longint'(leak_rate));
         diff  = clamp32(longint'(mrna[i]) - longint'(prot[i]));
         dp[i] = q_product(longint'(decay_ratio), longint'(diff));
      end
      for (int i = 0; i < 3; i++) begin
         mrna[i] = clamp32(longint'(mrna[i]) + longint'(q_product(h, longint'(dm[i]))));
         prot[i] = clamp32(longint'(prot[i]) + longint'(q_product(h, longint'(dp[i]))));
      end
      s = '{now_time, prot[1], res_pkg::STATUS_OK};
      now_time = clamp32(longint'(now_time) + h);
   endtask

   assign samples_pending = expected_samples.size();

   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         t_origin = 0; t_stop = 0; h_len = 31'd10486;
         max_rate = 0; leak_rate = 0; hill_exp = 4'd2; decay_ratio = 0;
         for (int i = 0; i < 3; i++) begin
            mrna[i] = 0;
            prot[i] = 0;
         end
         now_time = 0;
         loaded = 0;
         expected_samples.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               res_pkg::REG_START_TIME: t_origin = csr.data;
               res_pkg::REG_END_TIME:   t_stop = csr.data;
               res_pkg::REG_STEP_SIZE:  h_len = csr.data[30:0];
               res_pkg::REG_MAX_RATE:   max_rate = csr.data;
               res_pkg::REG_LEAK_RATE:  leak_rate = csr.data;
               res_pkg::REG_HILL_EXP:   hill_exp = csr.data[3:0];
               res_pkg::REG_DECAY:      decay_ratio = csr.data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: time %0d level %0d status %0d",
                           rsp.sample_time, rsp.reporter_level, rsp.step_status);
            end else begin
               s = expected_samples.pop_front();
               if (rsp.sample_time !== s.sample_time ||
                   rsp.reporter_level !== s.reporter_level ||
                   rsp.step_status !== s.step_status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp time %0d level %0d status %0d, got %0d %0d %0d",
                              s.sample_time, s.reporter_level, s.step_status,
                              rsp.sample_time, rsp.reporter_level, rsp.step_status);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.command == res_pkg::CMD_LOAD) begin
               mrna[0] = req.init_mrna_a; mrna[1] = req.init_mrna_b;
               mrna[2] = req.init_mrna_c;
               prot[0] = req.init_prot_a; prot[1] = req.init_prot_b;
               prot[2] = req.init_prot_c;
               now_time = t_origin;
               loaded = 1;
            end else begin
               euler_advance(s);
               expected_samples.insert(expected_samples.size(), s);
            end
         end
      end
   end

   initial mismatch_count = 0;

endmodule

// ----- test/tb_repressilator_euler_step_core.sv -----
// testbench top: stimulus, response back-pressure and verdict for the euler stepper
module tb_repressilator_euler_step_core;

   localparam int ONE = 1 << 20;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 1200;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   samples_pending;
   int   cycle_count;
   int   burst_left;
   int   hold_requests;
   int   holds_seen;
   int   hold_cycles;
   int   stall_mode;
   int   random_items;

   res_req_if req ();
   res_rsp_if rsp ();
   res_csr_if csr ();

   repressilator_euler_step_core uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   euler_step_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .mismatch_count(mismatch_count), .samples_pending(samples_pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[repressilator_euler_step_core] ERROR");
         $finish;
      end
   end

   // receiver: changing stall pattern plus one long hold-off in the second random phase
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_requests != holds_seen) begin
         holds_seen  <= hold_requests;
         hold_cycles <= 3000;
         rsp.ready   <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready   <= 1'b0;
      end else begin
         if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= $urandom_range(0, 1);
            2: rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [31:0] t0, logic [31:0] t1, logic [31:0] h,
                           logic [31:0] alpha, logic [31:0] alpha0, logic [31:0] n,
                           logic [31:0] beta);
      write_reg(res_pkg::REG_START_TIME, t0);
      write_reg(res_pkg::REG_END_TIME, t1);
      write_reg(res_pkg::REG_STEP_SIZE, h);
      write_reg(res_pkg::REG_MAX_RATE, alpha);
      write_reg(res_pkg::REG_LEAK_RATE, alpha0);
      write_reg(res_pkg::REG_HILL_EXP, n);
      write_reg(res_pkg::REG_DECAY, beta);
   endtask

   // one request transaction, sent in bursts with random gaps
   task automatic offer(logic cmd, logic [31:0] ma, logic [31:0] mb, logic [31:0] mc,
                        logic [31:0] pa, logic [31:0] pb, logic [31:0] pc);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid       <= 1'b1;
      req.command     <= cmd;
      req.init_mrna_a <= ma; req.init_mrna_b <= mb; req.init_mrna_c <= mc;
      req.init_prot_a <= pa; req.init_prot_b <= pb; req.init_prot_c <= pc;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic put_step();
      offer(res_pkg::CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic put_load(logic [31:0] ma, logic [31:0] mb, logic [31:0] mc,
                           logic [31:0] pa, logic [31:0] pb, logic [31:0] pc);
      offer(res_pkg::CMD_LOAD, ma, mb, mc, pa, pb, pc);
   endtask

   // wait out every result, then the longest step latency before touching registers
   task automatic settle();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] conc();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, 16 * ONE) - 4 * ONE;
   endfunction

   function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, logic [31:0] mid);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return $urandom;
         default: return mid;
      endcase
   endfunction

   task automatic random_regs();
      logic [31:0] t0;
      t0 = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64 * ONE) - 32 * ONE;
      set_regs(t0,
               pick(32'h8000_0000, 32'h7fff_ffff, t0 + $urandom_range(0, 4 * ONE)),
               pick(32'd1, 32'h7fff_ffff, $urandom_range(1, ONE / 4)),
               pick(32'h8000_0000, 32'h7fff_ffff, $urandom_range(0, 40 * ONE)),
               pick(32'h8000_0000, 32'h7fff_ffff, $urandom_range(0, ONE)),
               $urandom_range(0, 15),
               pick(32'h8000_0000, 32'h7fff_ffff, $urandom_range(0, 2 * ONE)));
   endtask

   initial begin
      int steps;
      reset       = 1'b1;
      cycle_count = 0;
      burst_left  = 0;
      hold_requests = 0;
      holds_seen  = 0;
      hold_cycles = 0;
      stall_mode  = 0;
      req.valid <= 1'b0; req.command <= res_pkg::CMD_LOAD;
      req.init_mrna_a <= 0; req.init_mrna_b <= 0; req.init_mrna_c <= 0;
      req.init_prot_a <= 0; req.init_prot_b <= 0; req.init_prot_c <= 0;
      csr.valid <= 1'b0; csr.index <= '0; csr.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: step before any load, extreme loads, then past end time
      put_step();
      put_load(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      put_step();
      put_step();
      put_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      put_step();
      settle();

      // repressor at minus one with n of one: zero denominator, positive alpha
      set_regs(0, 32'h7fff_ffff, ONE / 8, ONE, ONE / 16, 1, ONE);
      put_load(ONE, 2 * ONE, 3 * ONE, ONE / 2, ONE, -ONE);
      put_step();
      put_step();
      settle();

      // minimum alpha and hill exponent below range
      set_regs(ONE, 32'h7fff_ffff, ONE / 4, 32'h8000_0000, 32'h8000_0000, 0,
               32'h8000_0000);
      put_load(0, ONE, -ONE, -ONE, 5 * ONE, -ONE);
      put_step();
      put_step();
      settle();

      // hill exponent above range, zero step size leaves state alone
      set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
               32'h7fff_ffff, 15, 32'h7fff_ffff);
      put_load(ONE, ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
      put_step();
      put_step();
      settle();

      // time runs into the top of the format
      set_regs(32'h7ff0_0000, 32'h7fff_ffff, 32'h7fff_ffff, 3 * ONE, 0, 8, ONE / 2);
      put_load(ONE, 0, ONE, 0, ONE, 0);
      put_step();
      put_step();
      put_step();
      settle();

      // random phases: mostly a load followed by a run of steps, some noise
      random_items = 0;
      for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
         random_regs();
         if (phase == 1) hold_requests = hold_requests + 1;
         for (int k = 0; k < 200 && random_items < RANDOM_ITEMS; ) begin
            if ($urandom_range(0, 9) == 0) begin
               put_step();
               k++;
            end else begin
               put_load(conc(), conc(), conc(), conc(), conc(), conc());
               steps = $urandom_range(1, 15);
               repeat (steps) put_step();
               k += steps + 1;
               random_items += steps;
            end
            random_items++;
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("[repressilator_euler_step_core] OK");
      end else begin
         $display("[repressilator_euler_step_core] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/res_pkg.sv
rtl/core/res_stream_if.sv
rtl/core/res_div.sv
rtl/core/res_datapath.sv
rtl/core/res_ctrl.sv
rtl/core/repressilator_euler_step_core.sv
rtl/core/res_checker.sv
test/euler_step_checker.sv
test/tb_repressilator_euler_step_core.sv
